>>> sv/sstseq_pkg.sv
// Shared types, register indexes and constants for the step-and-settle test sequencer.
// Used by every module of the block; depends on nothing.
package sstseq_pkg;

  // Fixed-point position format: signed Q.FRACTION_BITS
  localparam int unsigned FRACTION_BITS = 4;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MAG    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TOL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READY_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRESH_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SPEED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_HOLD      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_HOLD      = 3'd7;

  // Reset values of the registers (distances in Q.FRACTION_BITS)
  localparam logic [14:0] RST_TARGET_MAG    = 15'(50 << FRACTION_BITS);
  localparam logic [14:0] RST_START_TOL     = 15'(5 << FRACTION_BITS);
  localparam logic [15:0] RST_READY_TIME    = 16'd200;
  localparam logic [15:0] RST_FRESH_TIMEOUT = 16'd200;
  localparam logic [14:0] RST_SETTLE_TOL    = 15'(5 << FRACTION_BITS);
  localparam logic [14:0] RST_SETTLE_SPEED  = 15'(10 << FRACTION_BITS);
  localparam logic [15:0] RST_POS_HOLD      = 16'd100;
  localparam logic [15:0] RST_NEG_HOLD      = 16'd300;

  // Peak error saturation limit
  localparam logic [14:0] PEAK_ERR_MAX = 15'h7FFF;

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  typedef enum logic [2:0] {
    MODE_READY    = 3'd0,
    MODE_MOVE_POS = 3'd1,
    MODE_HOLD_POS = 3'd2,
    MODE_MOVE_NEG = 3'd3,
    MODE_HOLD_NEG = 3'd4,
    MODE_DONE     = 3'd5,
    MODE_FAULT    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE        = 2'd0,
    FAULT_STALE       = 2'd1,
    FAULT_NOT_CENTRED = 2'd2
  } fault_e;

  // Configuration register set
  typedef struct packed {
    logic [14:0] target_magnitude;
    logic [14:0] start_tolerance;
    logic [15:0] ready_time;
    logic [15:0] fresh_timeout;
    logic [14:0] settle_tolerance;
    logic [14:0] settle_speed;
    logic [15:0] positive_hold_time;
    logic [15:0] negative_hold_time;
  } cfg_t;

  // Input item
  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        now_ms;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic               sample_valid;
    logic [31:0]        sample_stamp_ms;
  } in_t;

  // Result item
  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         fault_code;
    logic               ready_flag;
    logic signed [15:0] target;
    logic [31:0]        elapsed_ms;
    logic [14:0]        peak_error;
    logic               start_accepted;
    logic               loop_enabled;
    logic               drive_neutral;
  } out_t;

  // Magnitude of an 18-bit signed difference
  function automatic logic [17:0] abs18(input logic signed [17:0] v);
    abs18 = v[17] ? 18'(-v) : 18'(v);
  endfunction

endpackage

>>> sv/step_settle_test_sequencer_top.sv
// Top level of the step-and-settle test sequencer: input and result registers.
// Depends on sstseq_pkg, sstseq_cfg_regs and sstseq_core.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / in_data_i) carries one command item
//    (update, start or stop) with the current tick and a timestamped sample.
//  - Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
//    result item per command: mode, fault code, ready flag, target, elapsed time,
//    peak error and the per-step flags.
//  - Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//    write only while no command is in flight.
//  - Path: a command transfer lands in the input register; its state update lands
//    in the result register once that register is empty or being taken, and the
//    result transfer follows from there.
//  - Throughput: one command per cycle unless results stall; the state update
//    is one pass of compares and subtractions between input and result registers.
//  - Stall: while the result register is full and not taken, the input register
//    still takes one more command; further commands wait with in_ready_o low.
//  - Reset: registers return to their reset values, the sequencer is in ready
//    mode with no fault and both channels are empty.
module step_settle_test_sequencer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sstseq_pkg::in_t                   in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sstseq_pkg::out_t                  out_data_o,
  input  logic                              cfg_we_i,
  input  logic [sstseq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sstseq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sstseq_pkg::*;

  cfg_t  cfg;
  in_t   in_q;
  logic  in_valid_q;
  out_t  res;
  out_t  out_q;
  logic  out_valid_q;
  logic  step;

  // Move the held command into the result register when it has room
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sstseq_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sstseq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

endmodule

>>> sv/sstseq_cfg_regs.sv
// Configuration register file of the step-and-settle test sequencer.
// Depends on sstseq_pkg for register indexes, reset values and cfg_t.
module sstseq_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sstseq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sstseq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output sstseq_pkg::cfg_t                     cfg_o
);
  import sstseq_pkg::*;

  cfg_t cfg_q;

  // Register writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_magnitude   <= RST_TARGET_MAG;
      cfg_q.start_tolerance    <= RST_START_TOL;
      cfg_q.ready_time         <= RST_READY_TIME;
      cfg_q.fresh_timeout      <= RST_FRESH_TIMEOUT;
      cfg_q.settle_tolerance   <= RST_SETTLE_TOL;
      cfg_q.settle_speed       <= RST_SETTLE_SPEED;
      cfg_q.positive_hold_time <= RST_POS_HOLD;
      cfg_q.negative_hold_time <= RST_NEG_HOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_MAG:    cfg_q.target_magnitude   <= cfg_data_i[14:0];
        REG_START_TOL:     cfg_q.start_tolerance    <= cfg_data_i[14:0];
        REG_READY_TIME:    cfg_q.ready_time         <= cfg_data_i;
        REG_FRESH_TIMEOUT: cfg_q.fresh_timeout      <= cfg_data_i;
        REG_SETTLE_TOL:    cfg_q.settle_tolerance   <= cfg_data_i[14:0];
        REG_SETTLE_SPEED:  cfg_q.settle_speed       <= cfg_data_i[14:0];
        REG_POS_HOLD:      cfg_q.positive_hold_time <= cfg_data_i;
        REG_NEG_HOLD:      cfg_q.negative_hold_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/sstseq_core.sv
// Sequencer state and its combinational update for one command item.
// Depends on sstseq_pkg for the item types, mode and fault codes.
module sstseq_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sstseq_pkg::in_t    item_i,
  input  sstseq_pkg::cfg_t   cfg_i,
  output sstseq_pkg::out_t   res_o
);
  import sstseq_pkg::*;

  // State registers
  mode_e              mode_q, mode_d;
  fault_e             fault_q, fault_d;
  logic               ready_q, ready_d;
  logic signed [15:0] target_q, target_d;
  logic [31:0]        run_start_q, run_start_d;
  logic [31:0]        centred_since_q, centred_since_d;
  logic               centred_valid_q, centred_valid_d;
  logic [31:0]        settled_since_q, settled_since_d;
  logic signed [15:0] peak_pos_q, peak_pos_d;
  logic [14:0]        peak_err_q, peak_err_d;
  logic [31:0]        elapsed_q, elapsed_d;

  // Derived values
  logic               fresh;
  logic               centred;
  logic               stable;
  logic               clear_task;
  logic               accepted;
  logic               neutral;
  logic signed [15:0] pos_t;
  logic signed [15:0] neg_t;
  logic signed [15:0] stab_tgt;
  logic [31:0]        settled_age;
  logic [17:0]        peak_abs;

  // Freshness, centring and settling checks
  assign pos_t    = $signed({1'b0, cfg_i.target_magnitude});
  assign neg_t    = 16'(-pos_t);
  assign fresh    = item_i.sample_valid &&
                    ((item_i.now_ms - item_i.sample_stamp_ms) <= {16'b0, cfg_i.fresh_timeout});
  assign centred  = abs18(18'(item_i.position)) <= {3'b0, cfg_i.start_tolerance};
  assign stab_tgt = (mode_q == MODE_MOVE_POS || mode_q == MODE_HOLD_POS) ? pos_t : neg_t;
  assign stable   = (abs18(18'(item_i.position) - 18'(stab_tgt)) <= {3'b0, cfg_i.settle_tolerance})
                 && (abs18(18'(item_i.velocity)) <= {3'b0, cfg_i.settle_speed});
  assign settled_age = item_i.now_ms - settled_since_q;
  assign peak_abs    = abs18(18'(peak_pos_d) - 18'(pos_t));

  // Next state for one item
  always_comb begin
    mode_d          = mode_q;
    fault_d         = fault_q;
    ready_d         = ready_q;
    target_d        = target_q;
    run_start_d     = run_start_q;
    centred_since_d = centred_since_q;
    centred_valid_d = centred_valid_q;
    settled_since_d = settled_since_q;
    peak_pos_d      = peak_pos_q;
    peak_err_d      = peak_err_q;
    elapsed_d       = elapsed_q;
    clear_task      = 1'b0;
    accepted        = 1'b0;
    neutral         = 1'b0;

    case (item_i.cmd)
      CMD_STOP: begin
        clear_task = 1'b1;
        neutral    = 1'b1;
      end
      CMD_START: begin
        if (mode_q != MODE_READY) begin
          clear_task = 1'b1;
          neutral    = 1'b1;
        end else if (!ready_q) begin
          fault_d = fresh ? FAULT_NOT_CENTRED : FAULT_STALE;
        end else begin
          run_start_d     = item_i.now_ms;
          peak_pos_d      = item_i.position;
          settled_since_d = '0;
          elapsed_d       = '0;
          peak_err_d      = '0;
          fault_d         = FAULT_NONE;
          ready_d         = 1'b0;
          target_d        = pos_t;
          mode_d          = MODE_MOVE_POS;
          accepted        = 1'b1;
        end
      end
      CMD_UPDATE: begin
        case (mode_q)
          MODE_READY: begin
            target_d = '0;
            neutral  = 1'b1;
            if (fresh && centred) begin
              if (!centred_valid_q) begin
                centred_valid_d = 1'b1;
                centred_since_d = item_i.now_ms;
              end
              if ((item_i.now_ms - centred_since_d) >= {16'b0, cfg_i.ready_time}) begin
                ready_d = 1'b1;
                fault_d = FAULT_NONE;
              end
            end else begin
              centred_valid_d = 1'b0;
              centred_since_d = '0;
              ready_d         = 1'b0;
            end
          end
          MODE_FAULT: begin
            neutral = 1'b1;
          end
          default: begin
            // Run in progress: move, hold or done
            elapsed_d = item_i.now_ms - run_start_q;
            if (mode_q != MODE_DONE && !fresh) begin
              fault_d = FAULT_STALE;
              mode_d  = MODE_FAULT;
              ready_d = 1'b0;
              neutral = 1'b1;
            end else begin
              case (mode_q)
                MODE_MOVE_POS: begin
                  target_d = pos_t;
                  if (item_i.position > peak_pos_q) peak_pos_d = item_i.position;
                  if (stable) begin
                    mode_d          = MODE_HOLD_POS;
                    settled_since_d = item_i.now_ms;
                  end
                end
                MODE_HOLD_POS: begin
                  target_d = pos_t;
                  if (item_i.position > peak_pos_q) peak_pos_d = item_i.position;
                  if (!stable) begin
                    mode_d          = MODE_MOVE_POS;
                    settled_since_d = '0;
                  end else if (settled_age >= {16'b0, cfg_i.positive_hold_time}) begin
                    peak_err_d      = (peak_abs > 18'(PEAK_ERR_MAX)) ? PEAK_ERR_MAX
                                                                     : peak_abs[14:0];
                    target_d        = neg_t;
                    mode_d          = MODE_MOVE_NEG;
                    settled_since_d = '0;
                  end
                end
                MODE_MOVE_NEG: begin
                  target_d = neg_t;
                  if (stable) begin
                    mode_d          = MODE_HOLD_NEG;
                    settled_since_d = item_i.now_ms;
                  end
                end
                MODE_HOLD_NEG: begin
                  target_d = neg_t;
                  if (!stable) begin
                    mode_d          = MODE_MOVE_NEG;
                    settled_since_d = '0;
                  end else if (settled_age >= {16'b0, cfg_i.negative_hold_time}) begin
                    mode_d          = MODE_DONE;
                    settled_since_d = '0;
                  end
                end
                default: begin
                  target_d = neg_t;
                end
              endcase
            end
          end
        endcase
      end
      default: ;
    endcase

    // Stop, or start outside ready: back to the reset task state
    if (clear_task) begin
      mode_d          = MODE_READY;
      fault_d         = FAULT_NONE;
      ready_d         = 1'b0;
      target_d        = '0;
      run_start_d     = '0;
      centred_since_d = '0;
      centred_valid_d = 1'b0;
      settled_since_d = '0;
      peak_pos_d      = '0;
      peak_err_d      = '0;
      elapsed_d       = '0;
    end
  end

  // Result of this item, values after the step
  always_comb begin
    res_o.mode           = 3'(mode_d);
    res_o.fault_code     = 2'(fault_d);
    res_o.ready_flag     = ready_d;
    res_o.target         = target_d;
    res_o.elapsed_ms     = elapsed_d;
    res_o.peak_error     = peak_err_d;
    res_o.start_accepted = accepted;
    res_o.loop_enabled   = (mode_d >= MODE_MOVE_POS) && (mode_d <= MODE_DONE);
    res_o.drive_neutral  = neutral;
  end

  // State update on each item taken from the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_READY;
      fault_q         <= FAULT_NONE;
      ready_q         <= 1'b0;
      target_q        <= '0;
      run_start_q     <= '0;
      centred_since_q <= '0;
      centred_valid_q <= 1'b0;
      settled_since_q <= '0;
      peak_pos_q      <= '0;
      peak_err_q      <= '0;
      elapsed_q       <= '0;
    end else if (step_i) begin
      mode_q          <= mode_d;
      fault_q         <= fault_d;
      ready_q         <= ready_d;
      target_q        <= target_d;
      run_start_q     <= run_start_d;
      centred_since_q <= centred_since_d;
      centred_valid_q <= centred_valid_d;
      settled_since_q <= settled_since_d;
      peak_pos_q      <= peak_pos_d;
      peak_err_q      <= peak_err_d;
      elapsed_q       <= elapsed_d;
    end
  end

  // Consistency of the sequencer state
  a_ready_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> mode_q == MODE_READY)
    else $error("ready flag set outside ready mode");

  a_fault_is_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_FAULT |-> fault_q == FAULT_STALE)
    else $error("fault mode without stale measurement code");

  a_centred_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !centred_valid_q |-> centred_since_q == '0)
    else $error("centred timer holds a time while not running");

  a_start_begins_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && accepted |=> mode_q == MODE_MOVE_POS && run_start_q == $past(item_i.now_ms))
    else $error("accepted start did not begin a run");

endmodule

>>> dv/step_settle_test_sequencer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for step_settle_test_sequencer_top: directed and random command
// streams with a built-in sequencer predictor. Depends on sstseq_pkg and the top level only.
module step_settle_test_sequencer_top_test;
  import sstseq_pkg::*;

  localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned RANDOM_CMDS  = 850;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned REPORT_LINES = 60;

  // Predicts each result from the accepted commands and checks the block's results in order
  class step_sequence_checker;
    cfg_t        cfg;
    mode_e       mode;
    fault_e      fault;
    bit          ready;
    int          target;
    bit [31:0]   run_start;
    bit [31:0]   centred_since;
    bit          centred_valid;
    bit [31:0]   settled_since;
    int          peak_pos;
    logic [14:0] peak_err;
    bit [31:0]   elapsed;
    out_t        pending_results[$];
    int unsigned mismatches;

    function new();
      cfg = '{target_magnitude: RST_TARGET_MAG, start_tolerance: RST_START_TOL,
              ready_time: RST_READY_TIME, fresh_timeout: RST_FRESH_TIMEOUT,
              settle_tolerance: RST_SETTLE_TOL, settle_speed: RST_SETTLE_SPEED,
              positive_hold_time: RST_POS_HOLD, negative_hold_time: RST_NEG_HOLD};
      mismatches = 0;
      clear_run();
    endfunction

    function void clear_run();
      mode          = MODE_READY;
      fault         = FAULT_NONE;
      ready         = 1'b0;
      target        = 0;
      run_start     = '0;
      centred_since = '0;
      centred_valid = 1'b0;
      settled_since = '0;
      peak_pos      = 0;
      peak_err      = '0;
      elapsed       = '0;
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function bit settled(int pos, int vel, int tgt);
      return magnitude(pos - tgt) <= int'(cfg.settle_tolerance) &&
             magnitude(vel) <= int'(cfg.settle_speed);
    endfunction

    // One sequencer step: state update, then the result as seen after it
    function out_t advance_sequence(in_t c);
      bit [31:0]   now;
      bit [31:0]   age;
      int          pos;
      int          vel;
      int          pos_t;
      int          neg_t;
      bit          fresh;
      bit          accepted;
      bit          neutral;
      int unsigned err;
      out_t        o;
      now      = c.now_ms;
      pos      = $signed(c.position);
      vel      = $signed(c.velocity);
      age      = now - c.sample_stamp_ms;
      fresh    = c.sample_valid && (age <= 32'(cfg.fresh_timeout));
      pos_t    = int'(cfg.target_magnitude);
      neg_t    = -pos_t;
      accepted = 1'b0;
      neutral  = 1'b0;
      case (c.cmd)
        CMD_STOP: begin
          clear_run();
          neutral = 1'b1;
        end
        CMD_START: begin
          if (mode != MODE_READY) begin
            clear_run();
            neutral = 1'b1;
          end else if (!ready) begin
            fault = fresh ? FAULT_NOT_CENTRED : FAULT_STALE;
          end else begin
            run_start     = now;
            peak_pos      = pos;
            settled_since = '0;
            elapsed       = '0;
            peak_err      = '0;
            fault         = FAULT_NONE;
            ready         = 1'b0;
            target        = pos_t;
            mode          = MODE_MOVE_POS;
            accepted      = 1'b1;
          end
        end
        CMD_UPDATE: begin
          if (mode == MODE_READY) begin
            target  = 0;
            neutral = 1'b1;
            if (fresh && magnitude(pos) <= int'(cfg.start_tolerance)) begin
              if (!centred_valid) begin
                centred_valid = 1'b1;
                centred_since = now;
              end
              if (32'(now - centred_since) >= 32'(cfg.ready_time)) begin
                ready = 1'b1;
                fault = FAULT_NONE;
              end
            end else begin
              centred_valid = 1'b0;
              centred_since = '0;
              ready         = 1'b0;
            end
          end else if (mode == MODE_FAULT) begin
            neutral = 1'b1;
          end else begin
            elapsed = now - run_start;
            if (mode != MODE_DONE && !fresh) begin
              fault   = FAULT_STALE;
              mode    = MODE_FAULT;
              ready   = 1'b0;
              neutral = 1'b1;
            end else if (mode == MODE_MOVE_POS || mode == MODE_HOLD_POS) begin
              target = pos_t;
              if (pos > peak_pos) peak_pos = pos;
              if (mode == MODE_MOVE_POS) begin
                if (settled(pos, vel, pos_t)) begin
                  mode          = MODE_HOLD_POS;
                  settled_since = now;
                end
              end else if (!settled(pos, vel, pos_t)) begin
                mode          = MODE_MOVE_POS;
                settled_since = '0;
              end else if (32'(now - settled_since) >= 32'(cfg.positive_hold_time)) begin
                // peak error latched on leaving the positive hold, saturated
                err           = magnitude(peak_pos - pos_t);
                peak_err      = (err > PEAK_ERR_MAX) ? PEAK_ERR_MAX : 15'(err);
                target        = neg_t;
                mode          = MODE_MOVE_NEG;
                settled_since = '0;
              end
            end else if (mode == MODE_MOVE_NEG) begin
              target = neg_t;
              if (settled(pos, vel, neg_t)) begin
                mode          = MODE_HOLD_NEG;
                settled_since = now;
              end
            end else if (mode == MODE_HOLD_NEG) begin
              target = neg_t;
              if (!settled(pos, vel, neg_t)) begin
                mode          = MODE_MOVE_NEG;
                settled_since = '0;
              end else if (32'(now - settled_since) >= 32'(cfg.negative_hold_time)) begin
                mode          = MODE_DONE;
                settled_since = '0;
              end
            end else begin
              // done: no freshness check, parked at the negative target
              target = neg_t;
            end
          end
        end
        default: ;
      endcase
      o.mode           = mode;
      o.fault_code     = fault;
      o.ready_flag     = ready;
      o.target         = 16'(target);
      o.elapsed_ms     = elapsed;
      o.peak_error     = peak_err;
      o.start_accepted = accepted;
      o.loop_enabled   = (mode >= MODE_MOVE_POS) && (mode <= MODE_DONE);
      o.drive_neutral  = neutral;
      return o;
    endfunction

    function void take_command(in_t c);
      pending_results.push_back(advance_sequence(c));
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < REPORT_LINES) $display("%0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        flag_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch("result transfer with no result outstanding");
      end else begin
        want = pending_results.pop_front();
        compare_field("mode", 32'(got.mode), 32'(want.mode));
        compare_field("fault_code", 32'(got.fault_code), 32'(want.fault_code));
        compare_field("ready_flag", 32'(got.ready_flag), 32'(want.ready_flag));
        compare_field("target", 32'(got.target), 32'(want.target));
        compare_field("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
        compare_field("peak_error", 32'(got.peak_error), 32'(want.peak_error));
        compare_field("start_accepted", 32'(got.start_accepted), 32'(want.start_accepted));
        compare_field("loop_enabled", 32'(got.loop_enabled), 32'(want.loop_enabled));
        compare_field("drive_neutral", 32'(got.drive_neutral), 32'(want.drive_neutral));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  step_sequence_checker sb;
  bit [31:0]            clock_ms;
  int unsigned          n_commands = 0;
  int unsigned          cycles = 0;
  bit                   tx_calm = 1'b0;

  step_settle_test_sequencer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, short mostly, with calm stretches
  initial begin : result_sink
    int unsigned stall_left;
    bit          rx_calm;
    stall_left  = 0;
    rx_calm     = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) rx_calm = ~rx_calm;
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!rx_calm && $urandom_range(0, 99) < 15) begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 149) == 0) tx_calm = ~tx_calm;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Value within tol of c, edges favoured
  function automatic logic signed [15:0] near(int c, int tol);
    int off;
    case ($urandom_range(0, 3))
      0:       off = -tol;
      1:       off = tol;
      default: off = int'($urandom_range(0, 2 * tol)) - tol;
    endcase
    return clamp16(c + off);
  endfunction

  // Value just or well beyond tol from c
  function automatic logic signed [15:0] far(int c, int tol);
    int off;
    off = tol + 1 + int'($urandom_range(0, 300));
    if ($urandom_range(0, 1) != 0) off = -off;
    return clamp16(c + off);
  endfunction

  function automatic in_t mk(logic [1:0] cmd, logic [31:0] now, logic signed [15:0] pos,
                             logic signed [15:0] vel, logic valid, logic [31:0] stamp);
    in_t it;
    it.cmd             = cmd;
    it.now_ms          = now;
    it.position        = pos;
    it.velocity        = vel;
    it.sample_valid    = valid;
    it.sample_stamp_ms = stamp;
    return it;
  endfunction

  // Sample at the current tick, fresh or stale against the present timeout
  function automatic in_t sample(logic [1:0] cmd, logic signed [15:0] pos,
                                 logic signed [15:0] vel, bit fresh);
    bit [31:0] age;
    logic      valid;
    if (fresh) begin
      valid = 1'b1;
      age   = ($urandom_range(0, 4) == 0) ? 32'(sb.cfg.fresh_timeout)
                                          : $urandom_range(0, sb.cfg.fresh_timeout);
    end else begin
      valid = $urandom_range(0, 1);
      age   = ($urandom_range(0, 3) == 0) ? $urandom
                                          : 32'(sb.cfg.fresh_timeout) + 1 + $urandom_range(0, 3);
    end
    return mk(cmd, clock_ms, pos, vel, valid, clock_ms - age);
  endfunction

  function automatic in_t noise();
    in_t it;
    it.cmd             = $urandom_range(0, 3);
    it.now_ms          = $urandom;
    it.position        = 16'($urandom);
    it.velocity        = 16'($urandom);
    it.sample_valid    = $urandom_range(0, 1);
    it.sample_stamp_ms = ($urandom_range(0, 1) != 0) ? $urandom
                                                     : it.now_ms - $urandom_range(0, 300);
    return it;
  endfunction

  function automatic void step_clock(int unsigned span);
    clock_ms += $urandom_range(0, span / 2 + 1);
  endfunction

  function automatic int unsigned pick_level(int unsigned bits, int unsigned typical);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return (1 << bits) - 1;
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  function automatic cfg_t settings_for(int unsigned phase);
    cfg_t c;
    case (phase)
      1: c = '0;
      3: c = '1;
      4: c = '{target_magnitude: RST_TARGET_MAG, start_tolerance: RST_START_TOL,
               ready_time: RST_READY_TIME, fresh_timeout: RST_FRESH_TIMEOUT,
               settle_tolerance: RST_SETTLE_TOL, settle_speed: RST_SETTLE_SPEED,
               positive_hold_time: RST_POS_HOLD, negative_hold_time: RST_NEG_HOLD};
      default: begin
        c.target_magnitude   = 15'(pick_level(15, 2000));
        c.start_tolerance    = 15'(pick_level(15, 200));
        c.ready_time         = 16'(pick_level(16, 500));
        c.fresh_timeout      = 16'(pick_level(16, 500));
        c.settle_tolerance   = 15'(pick_level(15, 200));
        c.settle_speed       = 15'(pick_level(15, 400));
        c.positive_hold_time = 16'(pick_level(16, 500));
        c.negative_hold_time = 16'(pick_level(16, 500));
      end
    endcase
    return c;
  endfunction

  // Command transfer; valid held until taken, then an optional gap
  task automatic send(in_t item);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_command(item);
    if (item.cmd != CMD_UNKNOWN) n_commands++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic write_settings(cfg_t c);
    write_reg(REG_TARGET_MAG, 16'(c.target_magnitude));
    write_reg(REG_START_TOL, 16'(c.start_tolerance));
    write_reg(REG_READY_TIME, c.ready_time);
    write_reg(REG_FRESH_TIMEOUT, c.fresh_timeout);
    write_reg(REG_SETTLE_TOL, 16'(c.settle_tolerance));
    write_reg(REG_SETTLE_SPEED, 16'(c.settle_speed));
    write_reg(REG_POS_HOLD, c.positive_hold_time);
    write_reg(REG_NEG_HOLD, c.negative_hold_time);
    cfg_we_i <= 1'b0;
    sb.cfg = c;
  endtask

  // One test run: stop, centre until ready, start, then step through both targets
  task automatic run_sequence();
    int unsigned i;
    int unsigned r;
    int          tgt;
    int unsigned hold;
    if ($urandom_range(0, 3) == 0)
      clock_ms = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FC00;
    send(sample(CMD_STOP, 16'($urandom), 16'($urandom), $urandom_range(0, 1)));
    for (i = 0; i < 12 && !sb.ready; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(sample(CMD_UPDATE, 16'($urandom), 16'($urandom), $urandom_range(0, 1)));
      else
        send(sample(CMD_UPDATE, near(0, sb.cfg.start_tolerance), 16'($urandom), 1'b1));
      step_clock(sb.cfg.ready_time);
    end
    send(sample(CMD_START, near(0, sb.cfg.start_tolerance), 16'($urandom),
                $urandom_range(0, 7) != 0));
    for (i = 0; i < 40 && sb.mode >= MODE_MOVE_POS && sb.mode <= MODE_HOLD_NEG; i++) begin
      if (sb.mode <= MODE_HOLD_POS) begin
        tgt  = int'(sb.cfg.target_magnitude);
        hold = sb.cfg.positive_hold_time;
      end else begin
        tgt  = -int'(sb.cfg.target_magnitude);
        hold = sb.cfg.negative_hold_time;
      end
      r = $urandom_range(0, 39);
      if (r == 0)
        send(sample(CMD_UPDATE, near(tgt, sb.cfg.settle_tolerance), 16'($urandom), 1'b0));
      else if (r < 4)
        send(sample(CMD_UPDATE, far(tgt, sb.cfg.settle_tolerance),
                    near(0, sb.cfg.settle_speed), 1'b1));
      else if (r < 6)
        send(sample(CMD_UPDATE, near(tgt, sb.cfg.settle_tolerance),
                    far(0, sb.cfg.settle_speed), 1'b1));
      else
        send(sample(CMD_UPDATE, near(tgt, sb.cfg.settle_tolerance),
                    near(0, sb.cfg.settle_speed), 1'b1));
      step_clock(hold);
    end
    // afterwards: random updates in whatever mode the run ended, sometimes a further start
    repeat ($urandom_range(0, 3)) begin
      send(sample(CMD_UPDATE, 16'($urandom), 16'($urandom), $urandom_range(0, 1)));
      step_clock(100);
    end
    if ($urandom_range(0, 3) == 0)
      send(sample(CMD_START, 16'($urandom), 16'($urandom), $urandom_range(0, 1)));
  endtask

  // Stimulus
  initial begin
    int unsigned phase;
    int unsigned goal;
    sb         = new();
    clock_ms   = $urandom;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on reset settings
    send(mk(CMD_UNKNOWN, 32'h1234_5678, 16'sh7FFF, -16'sd32768, 1'b1, 32'h1234_5678));
    send(mk(CMD_START, 1000, 0, 0, 1'b1, 1000));           // start before ready, fresh
    send(mk(CMD_START, 1000, 0, 0, 1'b0, 1000));           // start before ready, stale
    send(mk(CMD_UPDATE, 0, 0, 0, 1'b1, 0));                // centred timer from tick zero
    send(mk(CMD_UPDATE, 200, 16, -16, 1'b1, 100));         // ready on the boundary
    send(mk(CMD_START, 210, -16'sd32768, 16'sh7FFF, 1'b1, 210));
    send(mk(CMD_UPDATE, 220, 800, 160, 1'b1, 220));        // settled at positive target
    send(mk(CMD_UPDATE, 320, 880, -160, 1'b1, 20));        // hold elapsed, but sample age over the timeout: stale fault
    send(mk(CMD_UPDATE, 330, -880, 0, 1'b1, 330));
    send(mk(CMD_UPDATE, 630, -720, 0, 1'b1, 630));         // update while faulted
    send(mk(CMD_UPDATE, 32'hFFFF_FFFF, 0, 0, 1'b0, 0));    // stale update while faulted
    send(mk(CMD_START, 640, 0, 0, 1'b1, 640));             // start outside ready mode
    send(mk(CMD_UPDATE, 5, -80, 0, 1'b1, 32'hFFFF_FFF0));  // sample age across the wrap
    send(mk(CMD_UPDATE, 300, 0, 0, 1'b1, 0));              // stale drops the centred timer
    send(mk(CMD_STOP, 32'hFFFF_FFFF, 16'sh7FFF, -16'sd32768, 1'b1, 32'hFFFF_FFFF));
    send(mk(CMD_UPDATE, 1000, 80, 0, 1'b1, 1000));
    send(mk(CMD_UPDATE, 1199, 0, 0, 1'b1, 1199));
    send(mk(CMD_UPDATE, 1200, 0, 0, 1'b1, 1200));
    send(mk(CMD_START, 1200, 0, 0, 1'b1, 1200));
    send(mk(CMD_UPDATE, 1500, 800, 0, 1'b1, 1299));        // vision fault
    send(mk(CMD_UPDATE, 1510, 800, 0, 1'b1, 1510));        // update while faulted
    send(mk(CMD_START, 1520, 0, 0, 1'b1, 1520));           // start in fault clears it
    wait_idle();

    // Widest targets and tolerances, zero times: peak error reaches full scale
    write_settings('{target_magnitude: 15'h7FFF, start_tolerance: 15'h7FFF, ready_time: '0,
                     fresh_timeout: 16'hFFFF, settle_tolerance: 15'h7FFF,
                     settle_speed: 15'h7FFF, positive_hold_time: '0, negative_hold_time: '0});
    send(mk(CMD_UPDATE, 7, -16'sd32767, -16'sd32768, 1'b1, 32'(7 - 65535)));
    send(mk(CMD_START, 9, -16'sd32768, 16'sh7FFF, 1'b1, 9));
    send(mk(CMD_UPDATE, 10, 0, -16'sd32767, 1'b1, 10));
    send(mk(CMD_UPDATE, 10, 0, 16'sh7FFF, 1'b1, 10));
    send(mk(CMD_UPDATE, 11, -16'sd32768, 0, 1'b1, 11));
    send(mk(CMD_UPDATE, 11, -16'sd32768, 0, 1'b1, 11));

    // Random part over several settings
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_settings(settings_for(phase));
      goal = n_commands + RANDOM_CMDS / PHASES;
      while (n_commands < goal) begin
        if ($urandom_range(0, 3) != 0) run_sequence();
        else repeat ($urandom_range(1, 4)) send(noise());
        if ($urandom_range(0, 29) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sstseq_pkg.sv
sv/sstseq_cfg_regs.sv
sv/sstseq_core.sv
sv/step_settle_test_sequencer_top.sv
dv/step_settle_test_sequencer_top_test.sv
